// ===== hw/rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and constants of the I2C transfer sequencer
// Item layouts, command codes, operation codes and register indexes.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Send buffer depth, set by the 4-bit byte_index field
  localparam int unsigned MaxBytes = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CntW     = 5;

  localparam logic [CntW-1:0] MaxCount = CntW'(MaxBytes);

  // Configuration register indexes
  localparam logic CfgTimeout   = 1'b0;
  localparam logic CfgSlaveAddr = 1'b1;

  localparam logic [15:0] TimeoutReset = 16'd10000;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpStart = 2'd1,
    OpTick  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CmdNone   = 3'd0,
    CmdStart  = 3'd1,
    CmdStop   = 3'd2,
    CmdAddrW  = 3'd3,
    CmdAddrR  = 3'd4,
    CmdSend   = 3'd5,
    CmdAckOn  = 3'd6,
    CmdAckOff = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [IdxW-1:0] byte_index;
    logic [7:0]      data_byte;
    logic [CntW-1:0] send_count;
    logic [CntW-1:0] receive_count;
    logic            bus_busy;
    logic            start_sent;
    logic            write_addr_acked;
    logic            byte_transmitted;
    logic            transfer_finished;
    logic            read_addr_acked;
    logic            byte_received;
  } in_item_t;

  typedef struct packed {
    cmd_e            command;
    logic [7:0]      command_byte;
    logic [4:0]      status;
    logic [CntW-1:0] bytes_written;
    logic [CntW-1:0] bytes_read;
    logic            read_valid;
    logic [7:0]      read_byte;
    logic            last;
  } out_item_t;

  // Outcome of one input item, queued between front and back
  typedef struct packed {
    logic            two;
    cmd_e            cmd0;
    logic [7:0]      byte0;
    cmd_e            cmd1;
    logic [7:0]      byte1;
    logic [4:0]      status;
    logic [CntW-1:0] written;
    logic [CntW-1:0] read;
    logic            rvalid;
    logic [7:0]      rbyte;
  } step_t;

endpackage

// ===== hw/rtl/i2cms_front.sv =====
// ----------------------------------------------------------------------------
// i2cms_front: item intake and transfer phase machine
// Classifies each item, updates the phase state and send buffer, and
// produces the commands and status of that item.
// ----------------------------------------------------------------------------
module i2cms_front
  import i2cms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic       acc_i,
  input  in_item_t   item_i,
  output step_t      step_o
);

  typedef enum logic [4:0] {
    PhIdle       = 5'd0,
    PhBusFree    = 5'd1,
    PhWrStart    = 5'd2,
    PhWrAddr     = 5'd3,
    PhWrByte     = 5'd4,
    PhWrDone     = 5'd5,
    PhRdStart    = 5'd6,
    PhRdAddr     = 5'd7,
    PhRdByte     = 5'd8,
    PhErrBusFree = 5'd9,
    PhErrWrStart = 5'd10,
    PhErrWrAddr  = 5'd11,
    PhErrWrByte  = 5'd12,
    PhErrWrDone  = 5'd13,
    PhErrRdStart = 5'd14,
    PhErrRdAddr  = 5'd15,
    PhErrRdByte  = 5'd16
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [16:0]     elapsed_q, elapsed_d;
  logic [CntW-1:0] wlen_q, wlen_d, rlen_q, rlen_d;
  logic [CntW-1:0] wcnt_q, wcnt_d, rcnt_q, rcnt_d;
  logic [15:0]     timeout_q;
  logic [6:0]      addr_q;
  logic [7:0]      sbuf_q [MaxBytes];

  logic            active, met;
  logic [CntW-1:0] sc, rc, wcnt_inc, rcnt_inc;
  logic [IdxW-1:0] fetch_idx;
  op_e             op;

  assign op       = op_e'(item_i.operation);
  assign active   = (phase_q >= PhBusFree) && (phase_q <= PhRdByte);
  assign sc       = (item_i.send_count > MaxCount) ? MaxCount : item_i.send_count;
  assign rc       = (item_i.receive_count > MaxCount) ? MaxCount : item_i.receive_count;
  assign wcnt_inc = wcnt_q + CntW'(1);
  assign rcnt_inc = rcnt_q + CntW'(1);
  assign fetch_idx = (phase_q == PhWrAddr) ? '0 : wcnt_inc[IdxW-1:0];

  always_comb begin
    unique case (phase_q)
      PhBusFree:             met = !item_i.bus_busy;
      PhWrStart, PhRdStart:  met = item_i.start_sent;
      PhWrAddr:              met = item_i.write_addr_acked;
      PhWrByte:              met = item_i.byte_transmitted;
      PhWrDone:              met = item_i.transfer_finished;
      PhRdAddr:              met = item_i.read_addr_acked;
      PhRdByte:              met = item_i.byte_received;
      default:               met = 1'b0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    wlen_d    = wlen_q;
    rlen_d    = rlen_q;
    wcnt_d    = wcnt_q;
    rcnt_d    = rcnt_q;
    step_o    = '0;
    step_o.cmd0 = CmdNone;
    step_o.cmd1 = CmdNone;

    if (acc_i) begin
      unique case (op)
        OpStart: begin
          if (!active && ((sc != '0) || (rc != '0))) begin
            wlen_d    = sc;
            rlen_d    = rc;
            wcnt_d    = '0;
            rcnt_d    = '0;
            elapsed_d = '0;
            phase_d   = PhBusFree;
          end
        end
        OpTick: begin
          if (active) begin
            if (met) begin
              elapsed_d = '0;
              unique case (phase_q)
                PhBusFree: begin
                  if (wlen_q != '0) begin
                    step_o.cmd0 = CmdStart;
                    phase_d     = PhWrStart;
                  end else begin
                    step_o.cmd0 = CmdAckOn;
                    step_o.cmd1 = CmdStart;
                    step_o.two  = 1'b1;
                    phase_d     = PhRdStart;
                  end
                end
                PhWrStart: begin
                  step_o.cmd0  = CmdAddrW;
                  step_o.byte0 = {addr_q, 1'b0};
                  phase_d      = PhWrAddr;
                end
                PhWrAddr: begin
                  step_o.cmd0  = CmdSend;
                  step_o.byte0 = sbuf_q[fetch_idx];
                  phase_d      = PhWrByte;
                end
                PhWrByte: begin
                  wcnt_d = wcnt_inc;
                  if (wcnt_inc < wlen_q) begin
                    step_o.cmd0  = CmdSend;
                    step_o.byte0 = sbuf_q[fetch_idx];
                  end else begin
                    phase_d = PhWrDone;
                  end
                end
                PhWrDone: begin
                  if (rlen_q != '0) begin
                    step_o.cmd0 = CmdAckOn;
                    step_o.cmd1 = CmdStart;
                    step_o.two  = 1'b1;
                    phase_d     = PhRdStart;
                  end else begin
                    step_o.cmd0 = CmdStop;
                    phase_d     = PhIdle;
                  end
                end
                PhRdStart: begin
                  step_o.cmd0  = CmdAddrR;
                  step_o.byte0 = {addr_q, 1'b1};
                  phase_d      = PhRdAddr;
                end
                PhRdAddr: begin
                  if (rlen_q == CntW'(1)) step_o.cmd0 = CmdAckOff;
                  phase_d = PhRdByte;
                end
                default: begin
                  // Byte received: hand it out, release ACK before the last one
                  step_o.rvalid = 1'b1;
                  step_o.rbyte  = item_i.data_byte;
                  rcnt_d        = rcnt_inc;
                  if (rcnt_inc < rlen_q) begin
                    if ((rcnt_inc + CntW'(1)) == rlen_q) step_o.cmd0 = CmdAckOff;
                  end else begin
                    step_o.cmd0 = CmdStop;
                    phase_d     = PhIdle;
                  end
                end
              endcase
            end else if (elapsed_q > {1'b0, timeout_q}) begin
              if (phase_q != PhBusFree) step_o.cmd0 = CmdStop;
              phase_d = phase_e'(phase_q + 5'd8);
            end else begin
              elapsed_d = elapsed_q + 17'd1;
            end
          end
        end
        default: ;
      endcase
    end

    step_o.status  = phase_d;
    step_o.written = wcnt_d;
    step_o.read    = rcnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      elapsed_q <= '0;
      wlen_q    <= '0;
      rlen_q    <= '0;
      wcnt_q    <= '0;
      rcnt_q    <= '0;
      timeout_q <= TimeoutReset;
      addr_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      wlen_q    <= wlen_d;
      rlen_q    <= rlen_d;
      wcnt_q    <= wcnt_d;
      rcnt_q    <= rcnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTimeout:   timeout_q <= cfg_wdata_i;
          CfgSlaveAddr: addr_q    <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
    end
  end

  // Send buffer: payload only, no reset
  always_ff @(posedge clk_i) begin
    if (acc_i && (op == OpLoad)) begin
      sbuf_q[item_i.byte_index] <= item_i.data_byte;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhErrRdByte) else $error("phase out of range");

  a_wcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= wlen_q) else $error("written count passed write length");

  a_rcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= rlen_q) else $error("read count passed read length");

endmodule

// ===== hw/rtl/i2cms_queue.sv =====
// ----------------------------------------------------------------------------
// i2cms_queue: short queue of per-item outcomes
// Register-based FIFO between the phase machine and the result sender.
// ----------------------------------------------------------------------------
module i2cms_queue
  import i2cms_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  step_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output step_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  step_t            mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntQW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntQW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wrap_inc(wptr_q);
      if (pop_i)  rptr_q <= wrap_inc(rptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntQW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntQW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

endmodule

// ===== hw/rtl/i2cms_back.sv =====
// ----------------------------------------------------------------------------
// i2cms_back: result sender
// Splits each queued outcome into one or two result items.
// ----------------------------------------------------------------------------
module i2cms_back
  import i2cms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  step_t     head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic sel_q;
  logic last;

  assign last        = !head_i.two || sel_q;
  assign out_valid_o = !empty_i;
  assign pop_o       = out_valid_o && out_ready_i && last;

  always_comb begin
    out_item_o.command       = sel_q ? head_i.cmd1 : head_i.cmd0;
    out_item_o.command_byte  = sel_q ? head_i.byte1 : head_i.byte0;
    out_item_o.status        = head_i.status;
    out_item_o.bytes_written = head_i.written;
    out_item_o.bytes_read    = head_i.read;
    out_item_o.read_valid    = head_i.rvalid;
    out_item_o.read_byte     = head_i.rbyte;
    out_item_o.last          = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      sel_q <= !last;
    end
  end

  a_sel_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (!empty_i && head_i.two)) else $error("second result without pair");

endmodule

// ===== hw/rtl/i2c_master_transfer_sequencer_top.sv =====
// Results: an accepted item's outcome is registered in the outcome queue,
// which absorbs bursts. Throughput: one input item per cycle while the queue
// has room; an item that issues two commands yields two result items.
// Reset: phase idle, counters zero, timeout 10000, slave address 0; the
// send buffer is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_top: I2C master write-then-read sequencer
// Loads a send buffer, runs the START / address / data / STOP sequence from
// ticked peripheral flags, and reports commands and phase status.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_top
  import i2cms_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  logic  in_acc;
  logic  q_full, q_empty, q_pop;
  step_t step, head;

  // Accept whenever the outcome queue has room; the front does its work
  // in the accepting cycle and pushes the outcome straight away.
  assign in_ready_o = !q_full;
  assign in_acc     = in_valid_i && in_ready_o;

  // Front: classify the item, advance the phase machine, build commands
  i2cms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (in_acc),
    .item_i      (in_item_i),
    .step_o      (step)
  );

  // Queue: decouple intake from a stalled result port
  i2cms_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .push_data_i (step),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  // Back: hand out one or two result items per outcome
  i2cms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("pop from empty queue");

endmodule
